FILE: rtl/dmcr_pkg.sv
// ----------------------------------------------------------------------------
// dmcr_pkg
// Shared codes for the DSP mailbox control register block: halfword
// offsets, control word bits, micro-code modes and mailbox constants.
// ----------------------------------------------------------------------------
package dmcr_pkg;

    // Halfword offsets with special behavior
    localparam logic [4:0] IDX_MBOX_HI    = 5'd0;
    localparam logic [4:0] IDX_MBOX_LO    = 5'd1;
    localparam logic [4:0] IDX_OUTBOX_HI  = 5'd2;
    localparam logic [4:0] IDX_OUTBOX_LO  = 5'd3;
    localparam logic [4:0] IDX_CTRL       = 5'd5;
    localparam logic [4:0] IDX_DMA_CNT_LO = 5'd21;

    // Control word bit masks
    localparam logic [15:0] CR_RES      = 16'h0001;
    localparam logic [15:0] CR_PIINT    = 16'h0002;
    localparam logic [15:0] CR_HALT     = 16'h0004;
    localparam logic [15:0] CR_AIDINT   = 16'h0008;
    localparam logic [15:0] CR_AIDMSK   = 16'h0010;
    localparam logic [15:0] CR_ARINT    = 16'h0020;
    localparam logic [15:0] CR_ARMSK    = 16'h0040;
    localparam logic [15:0] CR_DSPINT   = 16'h0080;
    localparam logic [15:0] CR_DSPMSK   = 16'h0100;
    localparam logic [15:0] CR_INITCODE = 16'h0400;
    localparam logic [15:0] CR_INIT     = 16'h0800;
    localparam logic [15:0] CR_W1C      = CR_AIDINT | CR_ARINT | CR_DSPINT;
    localparam logic [15:0] CR_RESET    = CR_HALT;

    // Mail words
    localparam logic [31:0] MAIL_ROM_READY  = 32'h8071FEED;
    localparam logic [31:0] MAIL_INIT_READY = 32'h80544348;
    localparam logic [31:0] MAIL_MIXER_UP   = 32'hDCD10000;
    localparam logic [31:0] MAIL_CMDLIST_OK = 32'hDCD10002;
    localparam logic [15:0] MAIL_CMDLIST_TAG = 16'hBABE;

    // Boot mail that switches the ROM to mixer mode
    localparam logic [7:0] BOOT_SWITCH_COUNT = 8'd10;
    localparam logic [7:0] BOOT_COUNT_MAX    = 8'd255;

    // Micro-code mode, one-hot
    typedef enum logic [2:0] {
        MODE_ROM   = 3'b001,
        MODE_INIT  = 3'b010,
        MODE_MIXER = 3'b100
    } t_mode;

endpackage

FILE: rtl/dsp_mailbox_control_regs.sv
// ----------------------------------------------------------------------------
// dsp_mailbox_control_regs
// Halfword register block of an audio DSP front end: control word,
// inbound mailbox, outbound mail queue, DMA and plain registers.
// ----------------------------------------------------------------------------
// One bus access enters per beat on the slave stream (tuser = 1 for a write,
// 0 for a read) and returns exactly one beat on the master stream carrying
// the read data (zero for writes) and the interrupt line as it stands after
// the access. It sustains one access per clock while results are taken:
// each access is fully decoded and its state updated while it sits in the
// input register, and its result then waits in the result register.
// The input side keeps accepting while a result waits, and stalls only when
// the result register is still full and not being taken. Releasing halt in
// the control word starts the ROM or init micro-code mode, which posts its
// greeting mail; the tenth boot mail moves the ROM to mixer mode. Outbound
// mails queue in OUTBOX_DEPTH entries; a mail posted to a full queue is
// dropped, though its interrupt bit is still raised. Reading the low half of
// the front mail pops it. Offsets without special behavior read back what
// was last written there, all zero after reset.
module dsp_mailbox_control_regs #(
    parameter int OUTBOX_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [4:0] halfword_index, [20:5] write_data
    input  logic        i_s_tuser,   // [0] action (1 = write)
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // [15:0] read_data, [16] interrupt
);

    localparam int HW = $clog2(OUTBOX_DEPTH);
    localparam int CW = $clog2(OUTBOX_DEPTH + 1);

    // Input register
    logic        r_in_valid;
    logic        r_in_write;
    logic [4:0]  r_in_idx;
    logic [15:0] r_in_wd;

    // Result register
    logic        r_out_valid;
    logic [15:0] r_out_rd;
    logic        r_out_irq;

    // Block state
    dmcr_pkg::t_mode r_mode, n_mode;
    logic [15:0]     r_cw, n_cw;
    logic [7:0]      r_boot, n_boot;
    logic            r_pend, n_pend;
    logic [31:0]     r_mbox, n_mbox;
    logic [HW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic [31:0]     r_queue [OUTBOX_DEPTH];
    logic [15:0]     r_regs [32];

    // Per-access decode results
    logic            adv;
    logic            push;
    logic [31:0]     push_mail;
    logic            q_we;
    logic [HW-1:0]   q_slot;
    logic [CW:0]     slot_sum;
    logic            reg_we;
    logic [15:0]     rd;
    logic            irq;
    logic [31:0]     head_mail;
    logic [15:0]     mail_hi;
    logic [7:0]      boot_inc;
    logic [15:0]     keep;

    // Advance when the result register is free or being drained
    assign adv        = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || adv;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_irq, r_out_rd};

    assign head_mail = r_queue[r_head];
    assign mail_hi   = {1'b1, r_mbox[30:16]};
    assign boot_inc  = (r_boot == dmcr_pkg::BOOT_COUNT_MAX) ? r_boot : r_boot + 8'd1;
    assign keep      = r_cw & dmcr_pkg::CR_W1C & ~r_in_wd;

    always_comb begin
        n_cw      = r_cw;
        n_mode    = r_mode;
        n_boot    = r_boot;
        n_pend    = r_pend;
        n_mbox    = r_mbox;
        n_head    = r_head;
        n_count   = r_count;
        push      = 1'b0;
        push_mail = '0;
        reg_we    = 1'b0;
        rd        = '0;
        if (r_in_write) begin
            unique case (r_in_idx)
                dmcr_pkg::IDX_MBOX_HI: begin
                    n_mbox[31:16] = r_in_wd;
                end
                dmcr_pkg::IDX_MBOX_LO: begin
                    // Deliver the mail, then drop the pending flag in bit 31
                    n_mbox = {1'b0, r_mbox[30:16], r_in_wd};
                    if (r_mode == dmcr_pkg::MODE_ROM) begin
                        n_boot = boot_inc;
                        if (boot_inc == dmcr_pkg::BOOT_SWITCH_COUNT) begin
                            n_mode    = dmcr_pkg::MODE_MIXER;
                            n_pend    = 1'b0;
                            push      = 1'b1;
                            push_mail = dmcr_pkg::MAIL_MIXER_UP;
                            n_cw      = n_cw | dmcr_pkg::CR_DSPINT;
                        end
                    end else if (r_mode != dmcr_pkg::MODE_INIT) begin
                        if (r_pend) begin
                            n_pend    = 1'b0;
                            push      = 1'b1;
                            push_mail = dmcr_pkg::MAIL_CMDLIST_OK;
                            n_cw      = n_cw | dmcr_pkg::CR_DSPINT;
                        end else if (mail_hi == dmcr_pkg::MAIL_CMDLIST_TAG) begin
                            n_pend = 1'b1;
                        end
                    end
                end
                dmcr_pkg::IDX_CTRL: begin
                    n_cw = (r_in_wd & ~(dmcr_pkg::CR_W1C | dmcr_pkg::CR_RES
                                        | dmcr_pkg::CR_PIINT)) | keep;
                    if ((r_in_wd & dmcr_pkg::CR_RES) != '0) begin
                        n_mode  = dmcr_pkg::MODE_ROM;
                        n_head  = '0;
                        n_count = '0;
                    end
                    // Init low wins over reset
                    if ((r_in_wd & dmcr_pkg::CR_INIT) == '0) begin
                        n_mode = dmcr_pkg::MODE_INIT;
                        n_cw   = n_cw & ~dmcr_pkg::CR_INITCODE;
                    end
                    // Halt released: start the selected mode
                    if ((r_cw & dmcr_pkg::CR_HALT) != '0
                        && (n_cw & dmcr_pkg::CR_HALT) == '0) begin
                        if (n_mode == dmcr_pkg::MODE_ROM) begin
                            push      = 1'b1;
                            push_mail = dmcr_pkg::MAIL_ROM_READY;
                            n_boot    = '0;
                        end else if (n_mode == dmcr_pkg::MODE_INIT) begin
                            push      = 1'b1;
                            push_mail = dmcr_pkg::MAIL_INIT_READY;
                        end
                    end
                end
                default: begin
                    reg_we = 1'b1;
                    if (r_in_idx == dmcr_pkg::IDX_DMA_CNT_LO) begin
                        n_cw = n_cw | dmcr_pkg::CR_ARINT;
                    end
                end
            endcase
        end else begin
            unique case (r_in_idx)
                dmcr_pkg::IDX_MBOX_HI: rd = r_mbox[31:16];
                dmcr_pkg::IDX_MBOX_LO: rd = r_mbox[15:0];
                dmcr_pkg::IDX_OUTBOX_HI: begin
                    if (r_count != '0) begin
                        rd = {1'b1, head_mail[30:16]};
                    end
                end
                dmcr_pkg::IDX_OUTBOX_LO: begin
                    // Pop the front mail
                    if (r_count != '0) begin
                        rd      = head_mail[15:0];
                        n_head  = (r_head == HW'(OUTBOX_DEPTH - 1)) ? '0 : r_head + HW'(1);
                        n_count = r_count - CW'(1);
                    end
                end
                dmcr_pkg::IDX_CTRL: rd = r_cw;
                default: rd = r_regs[r_in_idx];
            endcase
        end

        // Enqueue behind the (possibly flushed) queue, drop when full
        slot_sum = (CW + 1)'(n_head) + (CW + 1)'(n_count);
        if (slot_sum >= (CW + 1)'(OUTBOX_DEPTH)) begin
            slot_sum = slot_sum - (CW + 1)'(OUTBOX_DEPTH);
        end
        q_slot = slot_sum[HW-1:0];
        q_we   = push && (n_count < CW'(OUTBOX_DEPTH));
        if (q_we) begin
            n_count = n_count + CW'(1);
        end

        irq = ((n_cw & dmcr_pkg::CR_AIDINT) != '0 && (n_cw & dmcr_pkg::CR_AIDMSK) != '0)
           || ((n_cw & dmcr_pkg::CR_ARINT) != '0 && (n_cw & dmcr_pkg::CR_ARMSK) != '0)
           || ((n_cw & dmcr_pkg::CR_DSPINT) != '0 && (n_cw & dmcr_pkg::CR_DSPMSK) != '0);
    end

    // Input register: load a beat whenever the stage is free or advancing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_write <= i_s_tuser;
            r_in_idx   <= i_s_tdata[4:0];
            r_in_wd    <= i_s_tdata[20:5];
        end
    end

    // Result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (adv) begin
            r_out_rd  <= rd;
            r_out_irq <= irq;
        end
    end

    // Commit the state update of the access in the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cw    <= dmcr_pkg::CR_RESET;
            r_mode  <= dmcr_pkg::MODE_ROM;
            r_boot  <= '0;
            r_pend  <= 1'b0;
            r_mbox  <= '0;
            r_head  <= '0;
            r_count <= '0;
        end else if (adv) begin
            r_cw    <= n_cw;
            r_mode  <= n_mode;
            r_boot  <= n_boot;
            r_pend  <= n_pend;
            r_mbox  <= n_mbox;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Outbound mail queue, no reset: entries are read only once written
    always_ff @(posedge i_clk) begin
        if (adv && q_we) begin
            r_queue[q_slot] <= push_mail;
        end
    end

    // DMA and plain registers share one halfword array
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 32; i++) begin
                r_regs[i] <= '0;
            end
        end else if (adv && reg_we) begin
            r_regs[r_in_idx] <= r_in_wd;
        end
    end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the DSP mailbox control register block. A mirror of
// the register state predicts the read data and interrupt line of every
// access. Each returned beat is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import dmcr_pkg::*;

    localparam int OUTBOX_DEPTH  = 4;
    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 5;
    // Watchdog limit in time units, set far above the slowest legal run.
    localparam int RUN_LIMIT     = 4_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_ITEMS   = 260;
    localparam int SAT_MAILS     = 260;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic [4:0] IDX_PLAIN_LOW = 5'd4;
    localparam logic [4:0] IDX_LAST      = 5'd31;
    localparam logic [4:0] DMA_FIRST     = 5'd16;
    localparam logic [4:0] DMA_LAST      = 5'd23;

    // One access result: read data and interrupt line after the access
    typedef struct packed {
        logic [15:0] read_data;
        logic        irq;
    } reply_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;   // [4:0] halfword_index, [20:5] write_data
    logic        i_s_tuser;   // [0] action (1 = write)
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;   // [15:0] read_data, [16] interrupt

    dsp_mailbox_control_regs #(
        .OUTBOX_DEPTH(OUTBOX_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Mirror of the register block, at reset values
    // ------------------------------------------------------------------
    logic [15:0] ctl_word   = CR_RESET;
    t_mode       ucode_mode = MODE_ROM;
    logic [7:0]  boot_mails = 8'd0;
    logic        cmd_armed  = 1'b0;
    logic [31:0] mbox_in    = 32'd0;
    logic [31:0] ob_mail [OUTBOX_DEPTH] = '{default: 32'd0};
    int          ob_head    = 0;
    int          ob_count   = 0;
    logic [15:0] dma_regs [8]   = '{default: 16'd0};
    logic [15:0] plain_regs [32] = '{default: 16'd0};

    reply_t pending_replies [$];
    int     errors         = 0;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;

    // Queue an outbound mail; a full queue drops it but still raises the irq
    function automatic void post_outbox(input logic [31:0] mail, input logic raise_irq);
        int slot;
        if (ob_count < OUTBOX_DEPTH) begin
            slot = (ob_head + ob_count) % OUTBOX_DEPTH;
            ob_mail[slot] = mail;
            ob_count++;
        end
        if (raise_irq)
            ctl_word = ctl_word | CR_DSPINT;
    endfunction

    // Halt released: greet from the selected micro-code
    function automatic void start_microcode();
        if (ucode_mode == MODE_ROM) begin
            post_outbox(MAIL_ROM_READY, 1'b0);
            boot_mails = 8'd0;
        end else if (ucode_mode == MODE_INIT) begin
            post_outbox(MAIL_INIT_READY, 1'b0);
        end
    endfunction

    function automatic void deliver_mail(input logic [31:0] mail);
        if (ucode_mode == MODE_ROM) begin
            if (boot_mails < BOOT_COUNT_MAX)
                boot_mails++;
            if (boot_mails == BOOT_SWITCH_COUNT) begin
                ucode_mode = MODE_MIXER;
                cmd_armed  = 1'b0;
                post_outbox(MAIL_MIXER_UP, 1'b1);
            end
        end else if (ucode_mode != MODE_INIT) begin
            if (cmd_armed) begin
                cmd_armed = 1'b0;
                post_outbox(MAIL_CMDLIST_OK, 1'b1);
            end else if (mail[31:16] == MAIL_CMDLIST_TAG) begin
                cmd_armed = 1'b1;
            end
        end
    endfunction

    function automatic void write_ctl(input logic [15:0] v);
        logic [15:0] old_word;
        logic [15:0] keep;
        old_word = ctl_word;
        keep     = old_word & CR_W1C & ~v;
        ctl_word = (v & ~(CR_W1C | CR_RES | CR_PIINT)) | keep;
        if ((v & CR_RES) != 16'd0) begin
            ucode_mode = MODE_ROM;
            ob_head    = 0;
            ob_count   = 0;
        end
        // Init bit low wins over reset
        if ((v & CR_INIT) == 16'd0) begin
            ucode_mode = MODE_INIT;
            ctl_word   = ctl_word & ~CR_INITCODE;
        end
        if ((old_word & CR_HALT) != 16'd0 && (ctl_word & CR_HALT) == 16'd0)
            start_microcode();
    endfunction

    // Apply one access to the mirror and return the beat it must produce
    function automatic reply_t model_access(input logic wr, input logic [4:0] idx,
                                            input logic [15:0] data);
        reply_t r;
        r.read_data = 16'd0;
        if (wr == ACT_WRITE) begin
            case (idx)
                IDX_MBOX_HI: mbox_in[31:16] = data;
                IDX_MBOX_LO: begin
                    mbox_in[15:0] = data;
                    deliver_mail(mbox_in | 32'h8000_0000);
                    mbox_in[31] = 1'b0;
                end
                IDX_CTRL: write_ctl(data);
                default: begin
                    if (idx >= DMA_FIRST && idx <= DMA_LAST) begin
                        dma_regs[idx[2:0]] = data;
                        if (idx == IDX_DMA_CNT_LO)
                            ctl_word = ctl_word | CR_ARINT;
                    end else begin
                        plain_regs[idx] = data;
                    end
                end
            endcase
        end else begin
            case (idx)
                IDX_MBOX_HI: r.read_data = mbox_in[31:16];
                IDX_MBOX_LO: r.read_data = mbox_in[15:0];
                IDX_OUTBOX_HI: begin
                    if (ob_count != 0)
                        r.read_data = {1'b1, ob_mail[ob_head][30:16]};
                end
                IDX_OUTBOX_LO: begin
                    if (ob_count != 0) begin
                        r.read_data = ob_mail[ob_head][15:0];
                        ob_head     = (ob_head + 1) % OUTBOX_DEPTH;
                        ob_count--;
                    end
                end
                IDX_CTRL: r.read_data = ctl_word;
                default: begin
                    if (idx >= DMA_FIRST && idx <= DMA_LAST)
                        r.read_data = dma_regs[idx[2:0]];
                    else
                        r.read_data = plain_regs[idx];
                end
            endcase
        end
        r.irq = ((ctl_word & CR_AIDINT) != 0 && (ctl_word & CR_AIDMSK) != 0) ||
                ((ctl_word & CR_ARINT)  != 0 && (ctl_word & CR_ARMSK)  != 0) ||
                ((ctl_word & CR_DSPINT) != 0 && (ctl_word & CR_DSPMSK) != 0);
        return r;
    endfunction

    function automatic void flag_error(input string what, input reply_t want,
                                       input reply_t got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("ERROR at %0t: %s: expected rd=%04h irq=%0b, got rd=%04h irq=%0b",
                     $time, what, want.read_data, want.irq, got.read_data, got.irq);
    endfunction

    // ------------------------------------------------------------------
    // Sender: one access per call. Valid is lowered only while idling or draining,
    // so back-to-back beats keep it high without a second assignment.
    // ------------------------------------------------------------------
    task automatic send_access(input logic wr, input logic [4:0] idx, input logic [15:0] data);
        reply_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, data, idx};
        i_s_tuser  <= wr;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        // Beat accepted at this edge: predict its result
        predicted       = model_access(wr, idx, data);
        pending_replies = {pending_replies, predicted};
    endtask

    task automatic write_mail_lo(input logic [15:0] data);
        send_access(ACT_WRITE, IDX_MBOX_LO, data);
    endtask

    task automatic write_control(input logic [15:0] v);
        send_access(ACT_WRITE, IDX_CTRL, v);
    endtask

    // Hold the sender off until every outstanding beat has returned
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_replies.size() != 0);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct   = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // Random control word; keep the init bit set most of the time so the
    // block does not sit in init mode where mails are ignored.
    function automatic logic [15:0] random_ctl(input logic halt);
        logic [15:0] w;
        w = 16'($urandom);
        if ($urandom_range(7) != 0)
            w = w | CR_INIT;
        w = halt ? (w | CR_HALT) : (w & ~CR_HALT);
        return w;
    endfunction

    // Reset the ROM, release halt and send the ten boot mails
    task automatic boot_to_mixer(input logic [15:0] masks);
        logic [15:0] d;
        write_control(CR_HALT | CR_RES | CR_INIT | masks);
        write_control(CR_INIT | masks);
        repeat (BOOT_SWITCH_COUNT) begin
            d = 16'($urandom);
            write_mail_lo(d);
        end
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------
    task automatic test_register_readback();
        send_access(ACT_WRITE, IDX_PLAIN_LOW, 16'hFFFF);
        send_access(ACT_READ,  IDX_PLAIN_LOW, 16'hFFFF);
        send_access(ACT_WRITE, DMA_LAST, 16'hFFFF);
        send_access(ACT_READ,  DMA_LAST, 16'h0000);
        send_access(ACT_READ,  IDX_CTRL, 16'h0000);
    endtask

    task automatic test_rom_boot();
        // Release halt: the ROM greets, then ten mails switch to mixer mode
        write_control(CR_INIT | CR_DSPMSK);
        send_access(ACT_READ, IDX_OUTBOX_HI, 16'h0000);
        send_access(ACT_READ, IDX_OUTBOX_LO, 16'h0000);
        for (int i = 0; i < BOOT_SWITCH_COUNT; i++)
            write_mail_lo((i % 2 == 0) ? 16'h0000 : 16'hFFFF);
        send_access(ACT_READ, IDX_OUTBOX_HI, 16'h0000);
        send_access(ACT_READ, IDX_OUTBOX_LO, 16'h0000);
    endtask

    task automatic test_command_list();
        // Tag mail arms, the next mail is answered
        send_access(ACT_WRITE, IDX_MBOX_HI, MAIL_CMDLIST_TAG);
        write_mail_lo(16'h0000);
        write_mail_lo(16'hFFFF);
    endtask

    task automatic test_outbox_overflow();
        // Three more answers fill the queue
        repeat (6)
            write_mail_lo(16'h1234);
        // Clear the irq, then post into the full queue: mail dropped, irq set
        write_control(CR_INIT | CR_DSPMSK | CR_DSPINT);
        write_mail_lo(16'h5678);
        write_mail_lo(16'h9ABC);
        repeat (OUTBOX_DEPTH + 1)
            send_access(ACT_READ, IDX_OUTBOX_LO, 16'h0000);
    endtask

    task automatic test_init_mode_mail();
        // Init bit low selects init mode and clears init code
        write_control(CR_HALT | CR_INITCODE);
        write_control(16'h0000);
        write_mail_lo(16'hFFFF);
        send_access(ACT_READ, IDX_OUTBOX_HI, 16'h0000);
        send_access(ACT_READ, IDX_OUTBOX_LO, 16'h0000);
    endtask

    task automatic test_dma_interrupt();
        write_control(CR_INIT | CR_ARMSK);
        send_access(ACT_WRITE, IDX_DMA_CNT_LO, 16'hFFFF);
        write_control(CR_INIT | CR_ARMSK | CR_ARINT | CR_AIDINT);
    endtask

    task automatic test_control_extremes();
        write_control(16'hFFFF);
        send_access(ACT_READ, IDX_CTRL, 16'h0000);
    endtask

    // ROM mode entered by reset bit alone keeps the boot count, so the
    // count climbs past the switch value and must stick at its maximum.
    task automatic test_boot_count_saturation();
        logic [15:0] d;
        boot_to_mixer(CR_DSPMSK);
        write_control(CR_RES | CR_INIT | CR_DSPMSK);
        repeat (SAT_MAILS) begin
            d = 16'($urandom);
            write_mail_lo(d);
        end
        send_access(ACT_READ, IDX_OUTBOX_LO, 16'h0000);
        send_access(ACT_READ, IDX_CTRL, 16'h0000);
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly well-formed sequences with random content
    // ------------------------------------------------------------------
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_items);
        int          kind;
        int          sent;
        logic        wr;
        logic [4:0]  idx;
        logic [15:0] w;
        set_idling(send_pct, recv_pct);
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(99);
            w    = 16'($urandom);
            if (kind < 10) begin
                // Noise: any access at all
                wr  = 1'($urandom_range(1));
                idx = 5'($urandom_range(31));
                send_access(wr, idx, w);
                sent += 1;
            end else if (kind < 20) begin
                write_control(random_ctl(1'b1));
                write_control(random_ctl(1'b0));
                sent += 2;
            end else if (kind < 25) begin
                boot_to_mixer(w & (CR_AIDMSK | CR_ARMSK | CR_DSPMSK));
                sent += 2 + BOOT_SWITCH_COUNT;
            end else if (kind < 50) begin
                case ($urandom_range(3))
                    0:       w = MAIL_CMDLIST_TAG;
                    1:       w = MAIL_CMDLIST_TAG & 16'h7FFF;
                    default: ;
                endcase
                if ($urandom_range(1) == 1) begin
                    send_access(ACT_WRITE, IDX_MBOX_HI, w);
                    sent += 1;
                end
                w = 16'($urandom);
                write_mail_lo(w);
                sent += 1;
            end else if (kind < 68) begin
                if ($urandom_range(1) == 1) begin
                    send_access(ACT_READ, IDX_OUTBOX_HI, w);
                    sent += 1;
                end
                send_access(ACT_READ, IDX_OUTBOX_LO, w);
                sent += 1;
            end else if (kind < 78) begin
                idx = DMA_FIRST + 5'($urandom_range(7));
                wr  = 1'($urandom_range(1));
                send_access(wr, idx, w);
                sent += 1;
            end else if (kind < 88) begin
                write_control(random_ctl(w[2]));
                send_access(ACT_READ, IDX_CTRL, w);
                sent += 2;
            end else begin
                idx = 5'($urandom_range(31));
                send_access(ACT_WRITE, idx, w);
                send_access(ACT_READ, idx, w);
                sent += 2;
            end
        end
        // Let every beat of this phase come back before the next one
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready drawn fresh at every edge
    // ------------------------------------------------------------------
    always @(posedge i_clk)
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // ------------------------------------------------------------------
    // Result checker: compare each returned beat with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        reply_t got;
        reply_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.read_data = o_m_tdata[15:0];
            got.irq       = o_m_tdata[16];
            if (pending_replies.size() == 0) begin
                want = '0;
                flag_error("beat with no access waiting", want, got);
            end else begin
                want = pending_replies[0];
                pending_replies.delete(0);
                if (got.read_data !== want.read_data)
                    flag_error("read data mismatch", want, got);
                else if (got.irq !== want.irq)
                    flag_error("interrupt mismatch", want, got);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial begin
        #RUN_LIMIT;
        $display("tb failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= 24'd0;
        i_s_tuser  <= ACT_READ;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part runs without idling
        test_register_readback();
        test_rom_boot();
        test_command_list();
        test_outbox_overflow();
        test_init_mode_mail();
        test_dma_interrupt();
        test_control_extremes();
        // Pause the sender until the block has answered everything
        wait_drained();

        test_boot_count_saturation();
        test_random_traffic(0, 0, PHASE_ITEMS);
        test_random_traffic(81, 0, PHASE_ITEMS);
        test_random_traffic(0, 81, PHASE_ITEMS);
        test_random_traffic(31, 31, PHASE_ITEMS);

        // Drain, then give any stray beat a chance to show up
        wait_drained();
        set_idling(0, 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_replies.size() != 0)
            errors++;

        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
